FILE: rtl/cth_pkg.sv
// Shared types, constants and character-class helpers for the checkpoint token hasher.
// No dependencies; imported by cth_step and checkpoint_token_hasher.

package cth_pkg;

    // Hash and tag constants
    localparam logic [31:0] FNV_PRIME     = 32'd16777619;
    localparam logic [31:0] FNV_BASIS     = 32'd2166136261;
    localparam logic [63:0] TAG_PREFIX    = 64'h4E43455700000000;
    localparam logic [63:0] TAG_LOW_MASK  = 64'h00000000FFFFFFFF;

    // Marker " CKPT " length and the characters that matter
    localparam logic [2:0] MARK_LEN = 3'd6;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;

    typedef enum logic [2:0] {
        PH_SEARCH     = 3'd0,
        PH_TOK1_EMPTY = 3'd1,
        PH_TOK1       = 3'd2,
        PH_BLANKS     = 3'd3,
        PH_TOK2       = 3'd4,
        PH_DONE       = 3'd5,
        PH_FAIL       = 3'd6
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  marker_pos;
        logic [31:0] hash;
    } cth_state_t;

    typedef struct packed {
        logic        found;
        logic [63:0] tag;
    } cth_result_t;

    localparam cth_state_t STATE_RESET = '{phase: PH_SEARCH, marker_pos: 3'd0, hash: FNV_BASIS};

    // Expected marker character at a given match position
    function automatic logic [7:0] mark_byte(input logic [2:0] pos);
        logic [7:0] ch;
        begin
            case (pos)
                3'd0:    ch = CH_SPACE;
                3'd1:    ch = CH_C;
                3'd2:    ch = CH_K;
                3'd3:    ch = CH_P;
                3'd4:    ch = CH_T;
                3'd5:    ch = CH_SPACE;
                default: ch = CH_NUL;
            endcase
            return ch;
        end
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function automatic logic is_delim(input logic [7:0] b);
        return b inside {CH_NUL, CH_SPACE, CH_TAB, CH_CR, CH_LF};
    endfunction

endpackage

FILE: rtl/checkpoint_token_hasher.sv
// Checkpoint token hasher: finds " CKPT ", hashes the next two tokens with FNV-1a 32.
// Result path to m_axis: input register, then result register.
// Throughput: one item per cycle while no closing item stalls; one 32x32 multiply per step.
// A result register stalls only the item that closes a text; other items flow on.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser to search.
// Depends on cth_pkg and cth_step.

module checkpoint_token_hasher
    import cth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] witness_tag
    output logic        m_axis_tuser    // [0] found
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_present_reg;
    logic        in_last_reg;
    cth_state_t  state_reg;
    cth_state_t  state_next;
    cth_result_t step_result;
    logic        out_valid_reg;
    logic        out_found_reg;
    logic [63:0] out_tag_reg;
    logic        out_free;
    logic        in_fire;
    logic        out_load;

    // Handshake control
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_fire       = in_valid_reg && (!in_last_reg || out_free);
    assign out_load      = in_fire && in_last_reg;
    assign s_axis_tready = !in_valid_reg || in_fire;

    cth_step u_step (
        .cur          (state_reg),
        .text_byte    (in_byte_reg),
        .byte_present (in_present_reg),
        .last_byte    (in_last_reg),
        .nxt          (state_next),
        .result       (step_result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg    <= s_axis_tdata;
            in_present_reg <= s_axis_tuser;
            in_last_reg    <= s_axis_tlast;
        end
    end

    // Parser state: advance on every processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_found_reg <= step_result.found;
            out_tag_reg   <= step_result.tag;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tag_reg;
    assign m_axis_tuser  = out_found_reg;

    // A found result always carries the tag prefix in the upper word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[63:32] == TAG_PREFIX[63:32]))
        else $error("found result without tag prefix");

    // A failed result carries a zero tag
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 64'd0))
        else $error("failed result with non-zero tag");

    // The parser returns to its reset state after the closing item of a text
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_last_reg) |=> (state_reg == STATE_RESET))
        else $error("parser state not cleared after end of text");

    // Once past the search phase the whole marker has been matched
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase != PH_SEARCH) |-> (state_reg.marker_pos == MARK_LEN))
        else $error("parser left search without a full marker match");

endmodule

FILE: rtl/cth_step.sv
// Per-byte parser and FNV-1a hash step: next state and result from the current state.
// Depends on cth_pkg.

module cth_step
    import cth_pkg::*;
(
    input  cth_state_t  cur,
    input  logic [7:0]  text_byte,
    input  logic        byte_present,
    input  logic        last_byte,
    output cth_state_t  nxt,
    output cth_result_t result
);

    logic        do_mix;
    logic [7:0]  mix_b;
    logic [31:0] mixed;
    logic [31:0] mixed_hash;
    cth_state_t  consumed;
    logic        ok;

    // One FNV-1a round on the selected byte
    assign mixed      = cur.hash ^ {24'd0, mix_b};
    assign mixed_hash = mixed * FNV_PRIME;

    // Parse one byte
    always_comb
    begin
        consumed = cur;
        do_mix   = 1'b0;
        mix_b    = text_byte;
        if (byte_present)
        begin
            case (cur.phase)
                PH_SEARCH:
                begin
                    if ((cur.marker_pos < MARK_LEN) && (text_byte == mark_byte(cur.marker_pos)))
                    begin
                        consumed.marker_pos = cur.marker_pos + 3'd1;
                        if (cur.marker_pos + 3'd1 == MARK_LEN)
                        begin
                            consumed.phase = PH_TOK1_EMPTY;
                        end
                    end
                    else
                    begin
                        consumed.marker_pos = (text_byte == CH_SPACE) ? 3'd1 : 3'd0;
                    end
                end
                PH_TOK1_EMPTY:
                begin
                    if (is_delim(text_byte))
                    begin
                        consumed.phase = PH_FAIL;
                    end
                    else
                    begin
                        do_mix         = 1'b1;
                        consumed.phase = PH_TOK1;
                    end
                end
                PH_TOK1:
                begin
                    if (is_blank(text_byte))
                    begin
                        // fold a single space for the whole blank run
                        do_mix         = 1'b1;
                        mix_b          = CH_SPACE;
                        consumed.phase = PH_BLANKS;
                    end
                    else if (is_delim(text_byte))
                    begin
                        consumed.phase = PH_FAIL;
                    end
                    else
                    begin
                        do_mix = 1'b1;
                    end
                end
                PH_BLANKS:
                begin
                    if (is_blank(text_byte))
                    begin
                        consumed.phase = PH_BLANKS;
                    end
                    else if (is_delim(text_byte))
                    begin
                        consumed.phase = PH_FAIL;
                    end
                    else
                    begin
                        do_mix         = 1'b1;
                        consumed.phase = PH_TOK2;
                    end
                end
                PH_TOK2:
                begin
                    if (is_delim(text_byte))
                    begin
                        consumed.phase = PH_DONE;
                    end
                    else
                    begin
                        do_mix = 1'b1;
                    end
                end
                PH_DONE:
                begin
                    consumed.phase = PH_DONE;
                end
                default:
                begin
                    consumed.phase = PH_FAIL;
                end
            endcase
        end
        if (do_mix)
        begin
            consumed.hash = mixed_hash;
        end
    end

    // Form the result and return to reset at the end of the text
    always_comb
    begin
        ok           = (consumed.phase == PH_TOK2) || (consumed.phase == PH_DONE);
        result.found = ok;
        result.tag   = ok ? (TAG_PREFIX | ({32'd0, consumed.hash} & TAG_LOW_MASK)) : 64'd0;
        nxt          = last_byte ? STATE_RESET : consumed;
    end

endmodule
